// File: rtl/ppg_pkg.sv
// Shared types and constants for the progressive photon gather block.
// Depends on nothing; used by ppg_mul and progressive_photon_gather.
package ppg_pkg;

  localparam int unsigned NumPointsDef = 64;
  localparam int unsigned IdxW         = 6;
  localparam logic [15:0] AlphaReset   = 16'd45875;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_PHOTON = 2'd1,
    KIND_PASS   = 2'd2
  } kind_e;

  // One stored measurement point.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] radius;
    logic [31:0] pass_ph;
    logic [47:0] pass_fx;
    logic [31:0] tot_ph;
    logic [47:0] tot_fx;
  } point_t;

  // Operand pair for the shared multiplier.
  typedef struct packed {
    logic [47:0] a;
    logic [15:0] b;
  } mul_req_t;

endpackage

// File: rtl/ppg_mul.sv
// Shared 48x16 multiplier with a registered product.
// Depends on ppg_pkg for the operand struct.
module ppg_mul (
  input  logic              clk_i,
  input  ppg_pkg::mul_req_t req_i,
  output logic [63:0]       prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= 64'(req_i.a) * 64'(req_i.b);
  end

endmodule

// File: rtl/progressive_photon_gather.sv
// Top level of the progressive photon gather block: point memory, sequencer,
// restoring divider and square root. Depends on ppg_pkg and ppg_mul.
//
// Channel  | Dir | Signals                         | Content
// s_axis   | in  | tvalid tready tdata tuser       | load / photon / pass-end item
// m_axis   | out | tvalid tready tdata tlast       | photon hit flag or one point
// cfg      | in  | cfg_we_i cfg_wdata_i            | alpha, Q0.16
//
// A load is written while the block is idle. A photon walks all points
// through the one shared multiplier. A pass end puts each valid point with
// new photons through 32 divider steps, 16 root steps and 6 multiplies,
// skips the divider, root and scaling when the ratio saturates at one, and
// reports a point without new photons as it stands; invalid slots are skipped.
// Reset clears the valid bits, the sequencer and the output valid flag; the
// point memory itself is not cleared. The block is not ready while an item
// is being worked on; a finished result waits in the output register and
// stalls the sequencer only when the next result is due.
module progressive_photon_gather #(
  parameter int unsigned NUM_POINTS = ppg_pkg::NumPointsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [5:0] point_index, [21:6] pos_x, [37:22] pos_y, [53:38] pos_z,
  // [69:54] start_radius, [85:70] photon_power, [87:86] zero
  input  logic [87:0]  s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] hit_any, [6:1] out_index, [22:7] out_radius, [70:23] out_flux,
  // [102:71] out_photons, [103] zero
  output logic [103:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int unsigned AW   = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int unsigned PtrW = ppg_pkg::IdxW + 1;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_SCAN = 19'h00002,
    S_WAIT = 19'h00004,
    S_MX   = 19'h00008,
    S_MY   = 19'h00010,
    S_MZ   = 19'h00020,
    S_MR   = 19'h00040,
    S_AM   = 19'h00080,
    S_DIV  = 19'h00100,
    S_RR0  = 19'h00200,
    S_RR1  = 19'h00400,
    S_RD1  = 19'h00800,
    S_RD2  = 19'h01000,
    S_SQ   = 19'h02000,
    S_SC0  = 19'h04000,
    S_SC1  = 19'h08000,
    S_SC2  = 19'h10000,
    S_WB   = 19'h20000,
    S_EMIT = 19'h40000
  } state_e;

  function automatic logic [15:0] abs_diff(logic [15:0] a, logic [15:0] b);
    logic [16:0] d;
    d = {a[15], a} - {b[15], b};
    return d[16] ? 16'(-d) : d[15:0];
  endfunction

  // control state
  state_e                  state_q, state_d;
  logic [15:0]             alpha_q, alpha_d;
  logic [NUM_POINTS-1:0]   valid_q, valid_d;
  logic [PtrW-1:0]         ptr_q, ptr_d;
  logic                    out_valid_q, out_valid_d;

  // payload
  ppg_pkg::kind_e          kind_q, kind_d;
  logic [15:0]             px_q, px_d, py_q, py_d, pz_q, pz_d, pow_q, pow_d;
  logic                    hit_q, hit_d;
  logic [63:0]             acc_q, acc_d;
  logic [31:0]             rr_q, rr_d;
  logic [48:0]             den_q, den_d;
  logic [49:0]             rem_q, rem_d;
  logic [31:0]             quo_q, quo_d;
  logic [4:0]              cnt_q, cnt_d;
  logic [31:0]             sqv_q, sqv_d, sqr_q, sqr_d, sqb_q, sqb_d;
  logic [15:0]             new_r_q, new_r_d;
  logic [47:0]             new_f_q, new_f_d;
  logic [31:0]             new_n_q, new_n_d;
  logic [103:0]            out_data_q, out_data_d;
  logic                    out_last_q, out_last_d;

  // point memory
  ppg_pkg::point_t         mem_q [NUM_POINTS];
  ppg_pkg::point_t         rd_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  ppg_pkg::point_t         mem_wd;

  ppg_pkg::mul_req_t       mul_req;
  logic [63:0]             prod;

  ppg_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  logic [48:0]             s_sum;
  logic [47:0]             s_sat;
  logic [NUM_POINTS-1:0]   above;

  always_comb begin
    s_sum = {1'b0, rd_q.tot_fx} + {1'b0, rd_q.pass_fx};
    s_sat = s_sum[48] ? '1 : s_sum[47:0];
    for (int j = 0; j < NUM_POINTS; j++) begin
      above[j] = valid_q[j] && (PtrW'(j) > ptr_q);
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    logic [32:0] n_sum;
    logic [48:0] num;
    logic [49:0] rsh;
    logic [32:0] trial;
    logic [31:0] res_n;
    logic [63:0] wide;
    logic [48:0] fx_sum;

    state_d     = state_q;
    alpha_d     = alpha_q;
    valid_d     = valid_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    pow_d       = pow_q;
    hit_d       = hit_q;
    acc_d       = acc_q;
    rr_d        = rr_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    sqv_d       = sqv_q;
    sqr_d       = sqr_q;
    sqb_d       = sqb_q;
    new_r_d     = new_r_q;
    new_f_d     = new_f_q;
    new_n_d     = new_n_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_wa      = ptr_q[AW-1:0];
    mem_wd      = rd_q;
    mul_req     = '0;
    n_sum       = '0;
    num         = '0;
    rsh         = '0;
    trial       = '0;
    res_n       = '0;
    wide        = '0;
    fx_sum      = '0;

    if (cfg_we_i) begin
      alpha_d = cfg_wdata_i;
    end
    // drop the held result once the sink takes it
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d = ppg_pkg::kind_e'(s_axis_tuser_i);
          px_d   = s_axis_tdata_i[21:6];
          py_d   = s_axis_tdata_i[37:22];
          pz_d   = s_axis_tdata_i[53:38];
          pow_d  = s_axis_tdata_i[85:70];
          hit_d  = 1'b0;
          ptr_d  = '0;
          case (ppg_pkg::kind_e'(s_axis_tuser_i))
            ppg_pkg::KIND_LOAD: begin
              if ({1'b0, s_axis_tdata_i[5:0]} < PtrW'(NUM_POINTS)) begin
                mem_we         = 1'b1;
                mem_wa         = AW'(s_axis_tdata_i[5:0]);
                mem_wd.x       = s_axis_tdata_i[21:6];
                mem_wd.y       = s_axis_tdata_i[37:22];
                mem_wd.z       = s_axis_tdata_i[53:38];
                mem_wd.radius  = s_axis_tdata_i[69:54];
                mem_wd.pass_ph = '0;
                mem_wd.pass_fx = '0;
                mem_wd.tot_ph  = '0;
                mem_wd.tot_fx  = '0;
                valid_d[AW'(s_axis_tdata_i[5:0])] = 1'b1;
              end
            end
            ppg_pkg::KIND_PHOTON, ppg_pkg::KIND_PASS: begin
              state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (ptr_q == PtrW'(NUM_POINTS)) begin
          state_d = (kind_q == ppg_pkg::KIND_PHOTON) ? S_EMIT : S_IDLE;
        end else if (valid_q[ptr_q[AW-1:0]]) begin
          state_d = S_WAIT;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_WAIT: begin
        if (kind_q == ppg_pkg::KIND_PHOTON) begin
          mul_req.a = 48'(abs_diff(px_q, rd_q.x));
          mul_req.b = abs_diff(px_q, rd_q.x);
          state_d   = S_MX;
        end else if (rd_q.pass_ph == '0) begin
          // no new photons: report the point as it stands
          new_r_d = rd_q.radius;
          new_f_d = rd_q.tot_fx;
          new_n_d = rd_q.tot_ph;
          state_d = S_EMIT;
        end else begin
          mul_req.a = 48'(rd_q.pass_ph);
          mul_req.b = alpha_q;
          state_d   = S_AM;
        end
      end

      S_MX: begin
        acc_d     = prod;
        mul_req.a = 48'(abs_diff(py_q, rd_q.y));
        mul_req.b = abs_diff(py_q, rd_q.y);
        state_d   = S_MY;
      end

      S_MY: begin
        acc_d     = acc_q + prod;
        mul_req.a = 48'(abs_diff(pz_q, rd_q.z));
        mul_req.b = abs_diff(pz_q, rd_q.z);
        state_d   = S_MZ;
      end

      S_MZ: begin
        acc_d     = acc_q + prod;
        mul_req.a = 48'(rd_q.radius);
        mul_req.b = rd_q.radius;
        state_d   = S_MR;
      end

      S_MR: begin
        if (acc_q <= prod) begin
          hit_d          = 1'b1;
          mem_we         = 1'b1;
          mem_wd.pass_ph = (&rd_q.pass_ph) ? rd_q.pass_ph : rd_q.pass_ph + 1'b1;
          fx_sum         = {1'b0, rd_q.pass_fx} + 49'(pow_q);
          mem_wd.pass_fx = fx_sum[48] ? '1 : fx_sum[47:0];
        end
        ptr_d   = ptr_q + 1'b1;
        state_d = S_SCAN;
      end

      S_AM: begin
        n_sum   = {1'b0, rd_q.tot_ph} + {1'b0, prod[47:16]};
        new_n_d = n_sum[32] ? '1 : n_sum[31:0];
        num     = {1'b0, rd_q.tot_ph, 16'h0} + {1'b0, prod[47:0]};
        den_d   = {{1'b0, rd_q.tot_ph} + {1'b0, rd_q.pass_ph}, 16'h0};
        if (num >= den_d) begin
          new_r_d = rd_q.radius;
          new_f_d = s_sat;
          state_d = S_WB;
        end else begin
          rem_d   = {1'b0, num};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        // one restoring step per cycle
        rsh = {rem_q[48:0], 1'b0};
        if (rsh >= {1'b0, den_q}) begin
          rem_d = rsh - {1'b0, den_q};
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rsh;
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          state_d = S_RR0;
        end
      end

      S_RR0: begin
        mul_req.a = 48'(rd_q.radius);
        mul_req.b = rd_q.radius;
        state_d   = S_RR1;
      end

      S_RR1: begin
        rr_d      = prod[31:0];
        mul_req.a = 48'(prod[31:0]);
        mul_req.b = quo_q[15:0];
        state_d   = S_RD1;
      end

      S_RD1: begin
        acc_d     = prod;
        mul_req.a = 48'(rr_q);
        mul_req.b = quo_q[31:16];
        state_d   = S_RD2;
      end

      S_RD2: begin
        wide    = {prod[47:0], 16'h0} + acc_q;
        sqv_d   = wide[63:32];
        sqr_d   = '0;
        sqb_d   = 32'h4000_0000;
        cnt_d   = '0;
        state_d = S_SQ;
      end

      S_SQ: begin
        // one result bit per cycle
        trial = {1'b0, sqr_q} + {1'b0, sqb_q};
        if ({1'b0, sqv_q} >= trial) begin
          sqv_d = sqv_q - trial[31:0];
          res_n = (sqr_q >> 1) + sqb_q;
        end else begin
          res_n = sqr_q >> 1;
        end
        sqr_d = res_n;
        sqb_d = sqb_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd15) begin
          new_r_d = res_n[15:0];
          state_d = S_SC0;
        end
      end

      S_SC0: begin
        mul_req.a = s_sat;
        mul_req.b = quo_q[15:0];
        state_d   = S_SC1;
      end

      S_SC1: begin
        acc_d     = prod;
        mul_req.a = s_sat;
        mul_req.b = quo_q[31:16];
        state_d   = S_SC2;
      end

      S_SC2: begin
        wide    = prod + (acc_q >> 16);
        new_f_d = wide[63:16];
        state_d = S_WB;
      end

      S_WB: begin
        mem_we         = 1'b1;
        mem_wd.radius  = new_r_q;
        mem_wd.pass_ph = '0;
        mem_wd.pass_fx = '0;
        mem_wd.tot_ph  = new_n_q;
        mem_wd.tot_fx  = new_f_q;
        state_d        = S_EMIT;
      end

      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          if (kind_q == ppg_pkg::KIND_PHOTON) begin
            out_data_d = {103'h0, hit_q};
            out_last_d = 1'b1;
            state_d    = S_IDLE;
          end else begin
            out_data_d = {1'b0, new_n_q, new_f_q, new_r_q, ptr_q[5:0], 1'b0};
            out_last_d = ~|above;
            ptr_d      = ptr_q + 1'b1;
            state_d    = S_SCAN;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alpha_q     <= ppg_pkg::AlphaReset;
      valid_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alpha_q     <= alpha_d;
      valid_q     <= valid_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    px_q       <= px_d;
    py_q       <= py_d;
    pz_q       <= pz_d;
    pow_q      <= pow_d;
    hit_q      <= hit_d;
    acc_q      <= acc_d;
    rr_q       <= rr_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    sqv_q      <= sqv_d;
    sqr_q      <= sqr_d;
    sqb_q      <= sqb_d;
    new_r_q    <= new_r_d;
    new_f_q    <= new_f_d;
    new_n_q    <= new_n_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // point memory: one write port, one registered read port at the pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[ptr_q[AW-1:0]];
  end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for progressive_photon_gather: point loads, photon deposits and
// pass-end reductions checked against a bit-accurate predictor. Depends on ppg_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam int IDLE_LIMIT = 200000;
  localparam logic [1:0] KindUnused = 2'd3;

  typedef struct packed {
    logic        hit;
    logic [5:0]  idx;
    logic [15:0] radius;
    logic [47:0] flux;
    logic [31:0] photons;
    logic        last;
  } gather_res_t;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  idx;
    logic [15:0] px, py, pz, rad, pwr;
  } gather_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [87:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;
  logic m_axis_tlast_o;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  always #4 clk_i = ~clk_i;

  progressive_photon_gather dut (.*);

  // predictor state
  logic [15:0] pr_alpha;
  bit          pv_valid [NPTS];
  logic signed [15:0] pv_x [NPTS], pv_y [NPTS], pv_z [NPTS];
  logic [15:0] pv_r [NPTS];
  logic [31:0] pv_pph [NPTS], pv_tph [NPTS];
  logic [47:0] pv_pfx [NPTS], pv_tfx [NPTS];

  gather_res_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit rx_free = 1'b0;

  function automatic logic [63:0] sq_dist(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [17:0] d;
    d = 18'(a) - 18'(b);
    return 64'(d * d);
  endfunction

  function automatic logic [32:0] div_frac(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [31:0] q;
    if (num >= den) return 33'h1_0000_0000;
    rem = num;
    q = 0;
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem -= den;
        q[0] = 1'b1;
      end
    end
    return {1'b0, q};
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Work out the transfers one accepted item should cause and queue them.
  task automatic predict_gather(gather_item_t it);
    logic [63:0] d2, r2, n, m, num, den, np, s, rr;
    logic [32:0] d;
    gather_res_t r;
    bit hit;
    int cnt;
    case (it.kind)
      ppg_pkg::KIND_LOAD: begin
        pv_valid[it.idx] = 1'b1;
        pv_x[it.idx] = it.px;
        pv_y[it.idx] = it.py;
        pv_z[it.idx] = it.pz;
        pv_r[it.idx] = it.rad;
        pv_pph[it.idx] = 0;
        pv_pfx[it.idx] = 0;
        pv_tph[it.idx] = 0;
        pv_tfx[it.idx] = 0;
      end
      ppg_pkg::KIND_PHOTON: begin
        hit = 1'b0;
        for (int i = 0; i < NPTS; i++) begin
          if (!pv_valid[i]) continue;
          d2 = sq_dist(it.px, pv_x[i]) + sq_dist(it.py, pv_y[i]) + sq_dist(it.pz, pv_z[i]);
          r2 = 64'(pv_r[i]) * 64'(pv_r[i]);
          if (d2 <= r2) begin
            hit = 1'b1;
            if (pv_pph[i] != 32'hFFFF_FFFF) pv_pph[i]++;
            s = 64'(pv_pfx[i]) + 64'(it.pwr);
            pv_pfx[i] = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
          end
        end
        r = '0;
        r.hit = hit;
        r.last = 1'b1;
        expected_q.push_back(r);
      end
      ppg_pkg::KIND_PASS: begin
        cnt = 0;
        for (int i = 0; i < NPTS; i++) begin
          if (!pv_valid[i]) continue;
          n = pv_tph[i];
          m = pv_pph[i];
          if (m != 0) begin
            num = (n << 16) + 64'(pr_alpha) * m;
            den = (n + m) << 16;
            d = div_frac(num, den);
            if (!d[32]) begin
              rr = (64'(pv_r[i]) * 64'(pv_r[i]) * 64'(d[31:0])) >> 32;
              pv_r[i] = 16'(int_sqrt(rr));
            end
            np = n + ((64'(pr_alpha) * m) >> 16);
            pv_tph[i] = (np > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : np[31:0];
            s = 64'(pv_tfx[i]) + 64'(pv_pfx[i]);
            if (s > 64'hFFFF_FFFF_FFFF) s = 64'hFFFF_FFFF_FFFF;
            if (!d[32])
              s = ((s * 64'(d[31:16])) + ((s * 64'(d[15:0])) >> 16)) >> 16;
            pv_tfx[i] = s[47:0];
            pv_pph[i] = 0;
            pv_pfx[i] = 0;
          end
          r = '0;
          r.idx = 6'(i);
          r.radius = pv_r[i];
          r.flux = pv_tfx[i];
          r.photons = pv_tph[i];
          expected_q.push_back(r);
          cnt++;
        end
        if (cnt > 0) expected_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Check every output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    gather_res_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[0], m_axis_tdata_o[6:1], m_axis_tdata_o[22:7],
             m_axis_tdata_o[70:23], m_axis_tdata_o[102:71], m_axis_tlast_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.hit !== want.hit)
          $display("%0t: hit_any exp %h got %h", $time, want.hit, got.hit);
        if (got.idx !== want.idx)
          $display("%0t: out_index exp %0d got %0d", $time, want.idx, got.idx);
        if (got.radius !== want.radius)
          $display("%0t: out_radius exp %h got %h", $time, want.radius, got.radius);
        if (got.flux !== want.flux)
          $display("%0t: out_flux exp %h got %h", $time, want.flux, got.flux);
        if (got.photons !== want.photons)
          $display("%0t: out_photons exp %h got %h", $time, want.photons, got.photons);
        if (got.last !== want.last)
          $display("%0t: tlast exp %b got %b", $time, want.last, got.last);
        if (got !== want) errors++;
        if (m_axis_tdata_o[103] !== 1'b0) begin
          $display("%0t: pad bit exp 0 got %b", $time, m_axis_tdata_o[103]);
          errors++;
        end
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off while the sender keeps offering.
  always @(posedge clk_i) begin
    if (long_hold) m_axis_tready_i <= 1'b0;
    else if (rx_free) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog: end the run after too many cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  int burst_left = 0;

  // Offer one item; hold tvalid until the transfer, then predict it.
  task automatic send_item(gather_item_t it);
    if (burst_left == 0) begin
      @(posedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= it.kind;
    s_axis_tdata_i <= {2'b00, it.pwr, it.rad, it.pz, it.py, it.px, it.idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    predict_gather(it);
    if (burst_left == 0) s_axis_tvalid_i <= 1'b0;
  endtask

  // Drain the output, let any trailing work finish, then write alpha.
  task automatic set_alpha(logic [15:0] a);
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4200) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pr_alpha = a;
  endtask

  function automatic gather_item_t mk(logic [1:0] k, logic [5:0] i, logic [15:0] x,
                                      logic [15:0] y, logic [15:0] z, logic [15:0] r,
                                      logic [15:0] p);
    gather_item_t it;
    it.kind = k; it.idx = i; it.px = x; it.py = y; it.pz = z; it.rad = r; it.pwr = p;
    return it;
  endfunction

  // Random item: mostly photons near loaded points, some loads, pass ends and unused kinds.
  function automatic gather_item_t rand_item();
    int sel;
    logic [15:0] cx, cy, cz;
    sel = $urandom_range(0, 99);
    cx = 16'($urandom_range(0, 3) * 16'h1000 - 16'h2000);
    cy = 16'($urandom_range(0, 3) * 16'h1000 - 16'h2000);
    cz = 16'($urandom_range(0, 1) * 16'h2000);
    if (sel < 18)
      return mk(ppg_pkg::KIND_LOAD, 6'($urandom_range(0, 63)),
                cx + 16'($urandom_range(0, 511)),
                cy, cz, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                16'($urandom_range(16'h200, 16'h1800)), 16'($urandom));
    if (sel < 88)
      return mk(ppg_pkg::KIND_PHOTON, 6'($urandom),
                ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                cx + 16'($urandom_range(0, 4095)), cy + 16'($urandom_range(0, 2047)),
                cz + 16'($urandom_range(0, 2047)), 16'($urandom), 16'($urandom));
    if (sel < 97)
      return mk(ppg_pkg::KIND_PASS, 6'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
    return mk(KindUnused, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endfunction

  gather_item_t directed_tbl[$];
  gather_res_t  directed_exp[$];  // hand-typed photon results

  initial begin
    gather_res_t r;
    logic [15:0] alpha_set [4];
    alpha_set = '{16'd0, 16'hFFFF, 16'd32768, 16'd45875};
    pr_alpha = ppg_pkg::AlphaReset;
    foreach (pv_valid[i]) pv_valid[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: pass and photon before any load give nothing and a miss.
    directed_tbl = '{
      mk(ppg_pkg::KIND_PASS, 0, 0, 0, 0, 0, 0),
      mk(ppg_pkg::KIND_PHOTON, 0, 16'h8000, 16'h7FFF, 0, 0, 16'hFFFF),
      mk(KindUnused, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      mk(ppg_pkg::KIND_LOAD, 0, 0, 0, 0, 16'h1000, 0),
      mk(ppg_pkg::KIND_LOAD, 6'h3F, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0),
      mk(ppg_pkg::KIND_LOAD, 6'd5, 16'h8000, 16'h8000, 16'h8000, 0, 0),
      mk(ppg_pkg::KIND_PHOTON, 0, 0, 0, 0, 0, 16'hFFFF),
      mk(ppg_pkg::KIND_PHOTON, 0, 16'h1000, 0, 0, 0, 16'h0100),
      mk(ppg_pkg::KIND_PHOTON, 0, 16'h1001, 0, 0, 0, 16'h0100),
      mk(ppg_pkg::KIND_PHOTON, 0, 16'h8000, 16'h8000, 16'h8000, 0, 16'h0001),
      mk(ppg_pkg::KIND_PHOTON, 0, 16'h8000, 16'h7FFF, 16'h8000, 0, 16'h0001),
      mk(ppg_pkg::KIND_PHOTON, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 16'hFFFF),
      mk(ppg_pkg::KIND_PASS, 0, 0, 0, 0, 0, 0),
      mk(ppg_pkg::KIND_PASS, 0, 0, 0, 0, 0, 0)
    };
    r = '0;
    directed_exp = '{r, '{1'b0, 6'd0, 16'd0, 48'd0, 32'd0, 1'b1},
                     r, r, r, r,
                     '{1'b1, 6'd0, 16'd0, 48'd0, 32'd0, 1'b1},
                     '{1'b1, 6'd0, 16'd0, 48'd0, 32'd0, 1'b1},
                     '{1'b1, 6'd0, 16'd0, 48'd0, 32'd0, 1'b1},
                     '{1'b1, 6'd0, 16'd0, 48'd0, 32'd0, 1'b1},
                     '{1'b0, 6'd0, 16'd0, 48'd0, 32'd0, 1'b1},
                     '{1'b1, 6'd0, 16'd0, 48'd0, 32'd0, 1'b1},
                     r, r};
    foreach (directed_tbl[i]) begin
      send_item(directed_tbl[i]);
      // typed-in rows: photon results are readable at a glance
      if (directed_tbl[i].kind == ppg_pkg::KIND_PHOTON &&
          expected_q[$] !== directed_exp[i]) begin
        $display("%0t: directed row %0d exp %h predictor %h", $time, i, directed_exp[i],
                 expected_q[$]);
        errors++;
      end
    end

    // Phases over several alpha settings, extremes included.
    foreach (alpha_set[ph]) begin
      set_alpha(alpha_set[ph]);
      for (int k = 0; k < 75; k++) begin
        if (ph == 1 && k == 20) begin
          // long receiver hold-off while the sender keeps pushing photons
          fork
            begin
              long_hold = 1'b1;
              repeat (3000) @(posedge clk_i);
              long_hold = 1'b0;
            end
          join_none
        end
        rx_free = (ph == 2 && k >= 40);
        send_item(rand_item());
      end
      send_item(mk(ppg_pkg::KIND_PASS, 0, 0, 0, 0, 0, 0));
    end

    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/ppg_pkg.sv
rtl/ppg_mul.sv
rtl/progressive_photon_gather.sv
verif/tb_top.sv
